/* rtl/hbvws_pkg.sv */
// Shared types and constants for the heartbeat vote watchdog supervisor.
`default_nettype none

package hbvws_pkg;

	// Widths of the request fields and of the reported counters and ages.
	localparam int CMD_WIDTH          = 3;
	localparam int CFG_WIDTH          = 16;
	localparam int CFG_INDEX_WIDTH    = 2;
	localparam int REPORT_WIDTH       = 32;
	localparam int COUNT_WIDTH        = 32;
	localparam int TIME_WIDTH_DEFAULT = 32;

	// Reset values of the configuration registers.
	localparam logic [CFG_WIDTH-1:0] FEED_PERIOD_RESET  = 16'd250;
	localparam logic [CFG_WIDTH-1:0] STACK_PERIOD_RESET = 16'd1000;
	localparam logic [CFG_WIDTH-1:0] STALL_RESET        = 16'd1000;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_FEED_PERIOD  = 2'd0,
		CFG_STACK_PERIOD = 2'd1,
		CFG_STALL_LIMIT  = 2'd2
	} cfg_index_t;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_TICK         = 3'd0,
		CMD_HEARTBEAT    = 3'd1,
		CMD_CONTROL      = 3'd2,
		CMD_ATTACH       = 3'd3,
		CMD_START        = 3'd4,
		CMD_STACK_ENABLE = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_EARLY   = 2'd0,
		MODE_BOOT    = 2'd1,
		MODE_RUNNING = 2'd2,
		MODE_FATAL   = 2'd3
	} mode_t;

	typedef enum logic {
		FAULT_STACK = 1'b0,
		FAULT_STALL = 1'b1
	} fault_kind_t;

	// One result as it leaves the supervisor core.
	typedef struct packed {
		logic                    feed_pulse;
		logic                    fault_request;
		fault_kind_t             fault_kind;
		mode_t                   mode_now;
		logic [REPORT_WIDTH-1:0] feeds_done;
		logic [REPORT_WIDTH-1:0] votes_missed;
		logic                    guard_status;
		logic [REPORT_WIDTH-1:0] feed_age;
		logic [REPORT_WIDTH-1:0] foreground_age;
		logic [REPORT_WIDTH-1:0] control_age;
	} hbvws_result_t;

endpackage

`default_nettype wire

/* rtl/hbvws_core.sv */
// Supervisor state, configuration registers and the per-request update logic.
`default_nettype none

module hbvws_core import hbvws_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0]       cfg_data,
	input  wire logic                       step,
	input  wire logic [CMD_WIDTH-1:0]       step_cmd,
	input  wire logic                       step_good,
	output hbvws_result_t                   result
);

	typedef logic [TIME_WIDTH-1:0]  time_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	logic [CFG_WIDTH-1:0] feed_period_q, stack_period_q, stall_limit_q;

	mode_t  mode_q, mode_d;
	logic   attached_q, attached_d;
	logic   stack_on_q, stack_on_d;
	logic   guard_q, guard_d;
	logic   fatal_q, fatal_d;
	time_t  time_q, time_d;
	time_t  last_vote_q, last_vote_d;
	time_t  last_stack_q, last_stack_d;
	time_t  last_ctrl_q, last_ctrl_d;
	time_t  last_fg_q, last_fg_d;
	time_t  last_feed_q, last_feed_d;
	count_t fg_count_q, fg_count_d;
	count_t ctrl_count_q, ctrl_count_d;
	count_t fed_fg_q, fed_fg_d;
	count_t fed_ctrl_q, fed_ctrl_d;
	count_t feed_total_q, feed_total_d;
	count_t missed_q, missed_d;

	logic        feed_ev, fault_ev;
	fault_kind_t kind_ev;
	logic        stack_due, vote_due, stall_due, stack_fault, guard_now;
	count_t      fg_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_period_q  <= FEED_PERIOD_RESET;
			stack_period_q <= STACK_PERIOD_RESET;
			stall_limit_q  <= STALL_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_FEED_PERIOD:  feed_period_q  <= cfg_data;
				CFG_STACK_PERIOD: stack_period_q <= cfg_data;
				CFG_STALL_LIMIT:  stall_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_d       = mode_q;
		attached_d   = attached_q;
		stack_on_d   = stack_on_q;
		guard_d      = guard_q;
		fatal_d      = fatal_q;
		time_d       = time_q;
		last_vote_d  = last_vote_q;
		last_stack_d = last_stack_q;
		last_ctrl_d  = last_ctrl_q;
		last_fg_d    = last_fg_q;
		last_feed_d  = last_feed_q;
		fg_count_d   = fg_count_q;
		ctrl_count_d = ctrl_count_q;
		fed_fg_d     = fed_fg_q;
		fed_ctrl_d   = fed_ctrl_q;
		feed_total_d = feed_total_q;
		missed_d     = missed_q;
		feed_ev      = 1'b0;
		fault_ev     = 1'b0;
		kind_ev      = FAULT_STACK;

		stack_due   = stack_on_q &&
			((time_q - last_stack_q) >= TIME_WIDTH'(stack_period_q));
		vote_due    = attached_q &&
			((time_q - last_vote_q) >= TIME_WIDTH'(feed_period_q));
		stall_due   = (time_q - last_ctrl_q) >= TIME_WIDTH'(stall_limit_q);
		stack_fault = stack_due && !step_good && !fatal_q;
		guard_now   = stack_due ? step_good : guard_q;
		fg_inc      = fg_count_q + 1'b1;

		if (step) begin
			case (cmd_t'(step_cmd))
				CMD_TICK: begin
					time_d = time_q + 1'b1;
				end
				CMD_HEARTBEAT: begin
					fg_count_d = fg_inc;
					last_fg_d  = time_q;
					guard_d    = guard_now;
					if (stack_due) begin
						last_stack_d = time_q;
					end
					// A stack fault ends the pass, so no vote follows it.
					if (stack_fault) begin
						fatal_d  = 1'b1;
						mode_d   = MODE_FATAL;
						fault_ev = 1'b1;
						kind_ev  = FAULT_STACK;
					end else if (vote_due) begin
						last_vote_d = time_q;
						if (mode_q == MODE_BOOT) begin
							feed_total_d = feed_total_q + 1'b1;
							last_feed_d  = time_q;
							feed_ev      = 1'b1;
						end else if (mode_q == MODE_RUNNING) begin
							if (stall_due && !fatal_q) begin
								missed_d = missed_q + 1'b1;
								fatal_d  = 1'b1;
								mode_d   = MODE_FATAL;
								fault_ev = 1'b1;
								kind_ev  = FAULT_STALL;
							end else if (fg_inc != fed_fg_q &&
								ctrl_count_q != fed_ctrl_q && guard_now) begin
								feed_total_d = feed_total_q + 1'b1;
								last_feed_d  = time_q;
								feed_ev      = 1'b1;
								fed_fg_d     = fg_inc;
								fed_ctrl_d   = ctrl_count_q;
							end else begin
								missed_d = missed_q + 1'b1;
							end
						end
					end
				end
				CMD_CONTROL: begin
					ctrl_count_d = ctrl_count_q + 1'b1;
					last_ctrl_d  = time_q;
				end
				CMD_ATTACH: begin
					if (!fatal_q) begin
						attached_d   = 1'b1;
						mode_d       = MODE_BOOT;
						last_vote_d  = time_q;
						last_feed_d  = time_q;
						feed_total_d = feed_total_q + 1'b1;
						feed_ev      = 1'b1;
					end
				end
				CMD_START: begin
					if (!fatal_q) begin
						mode_d      = MODE_RUNNING;
						fed_fg_d    = fg_count_q;
						fed_ctrl_d  = ctrl_count_q;
						last_fg_d   = time_q;
						last_ctrl_d = time_q;
						last_vote_d = time_q;
						if (attached_q) begin
							feed_total_d = feed_total_q + 1'b1;
							last_feed_d  = time_q;
							feed_ev      = 1'b1;
						end
					end
				end
				CMD_STACK_ENABLE: begin
					stack_on_d   = 1'b1;
					guard_d      = step_good;
					last_stack_d = time_q;
				end
				default: ;
			endcase
		end

		result.feed_pulse     = feed_ev;
		result.fault_request  = fault_ev;
		result.fault_kind     = kind_ev;
		result.mode_now       = mode_d;
		result.feeds_done     = REPORT_WIDTH'(feed_total_d);
		result.votes_missed   = REPORT_WIDTH'(missed_d);
		result.guard_status   = guard_d;
		result.feed_age       = REPORT_WIDTH'(time_t'(time_d - last_feed_d));
		result.foreground_age = REPORT_WIDTH'(time_t'(time_d - last_fg_d));
		result.control_age    = REPORT_WIDTH'(time_t'(time_d - last_ctrl_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_EARLY;
			attached_q   <= 1'b0;
			stack_on_q   <= 1'b0;
			guard_q      <= 1'b1;
			fatal_q      <= 1'b0;
			time_q       <= '0;
			last_vote_q  <= '0;
			last_stack_q <= '0;
			last_ctrl_q  <= '0;
			last_fg_q    <= '0;
			last_feed_q  <= '0;
			fg_count_q   <= '0;
			ctrl_count_q <= '0;
			fed_fg_q     <= '0;
			fed_ctrl_q   <= '0;
			feed_total_q <= '0;
			missed_q     <= '0;
		end else begin
			mode_q       <= mode_d;
			attached_q   <= attached_d;
			stack_on_q   <= stack_on_d;
			guard_q      <= guard_d;
			fatal_q      <= fatal_d;
			time_q       <= time_d;
			last_vote_q  <= last_vote_d;
			last_stack_q <= last_stack_d;
			last_ctrl_q  <= last_ctrl_d;
			last_fg_q    <= last_fg_d;
			last_feed_q  <= last_feed_d;
			fg_count_q   <= fg_count_d;
			ctrl_count_q <= ctrl_count_d;
			fed_fg_q     <= fed_fg_d;
			fed_ctrl_q   <= fed_ctrl_d;
			feed_total_q <= feed_total_d;
			missed_q     <= missed_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/heartbeat_vote_watchdog_supervisor.sv */
// Top level of the heartbeat vote watchdog supervisor: handshakes and stage registers.
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     command, stack_guard_good
// output    out_valid / out_stall   feed_pulse .. control_age
// config    cfg_we                  cfg_index, cfg_data
//
// Each request is captured in the input register, updates the supervisor
// state combinationally and lands in the result register; a stall on the
// output can hold it in the input register in between. One request per
// cycle is sustained while out_stall stays low. The state update is a
// single pass of compares, adds and 32-bit increments.
// Reset clears all state to early mode with a healthy guard and loads the
// default periods. A stalled result holds in the result register while one
// more request waits in the input register; only when both are full does
// in_stall rise.

module heartbeat_vote_watchdog_supervisor import hbvws_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0]       cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [CMD_WIDTH-1:0]       command,
	input  wire logic                       stack_guard_good,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            feed_pulse,
	output logic                            fault_request,
	output logic                            fault_kind,
	output logic [1:0]                      mode_now,
	output logic [REPORT_WIDTH-1:0]         feeds_done,
	output logic [REPORT_WIDTH-1:0]         votes_missed,
	output logic                            guard_status,
	output logic [REPORT_WIDTH-1:0]         feed_age,
	output logic [REPORT_WIDTH-1:0]         foreground_age,
	output logic [REPORT_WIDTH-1:0]         control_age
);

	logic                 valid_s1;
	logic [CMD_WIDTH-1:0] cmd_s1;
	logic                 good_s1;
	logic                 out_valid_q;
	hbvws_result_t        result_q;
	hbvws_result_t        result;
	logic                 advance;
	logic                 accept;
	logic                 step;

	// The input register moves on whenever the result register is free or
	// is being emptied in this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign step     = valid_s1 && advance;

	hbvws_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.step_cmd  (cmd_s1),
		.step_good (good_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !advance);
			out_valid_q <= step || (out_valid_q && out_stall);
		end
	end

	// Payload registers carry no reset; their valid bits guard them.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			good_s1 <= stack_guard_good;
		end
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign feed_pulse     = result_q.feed_pulse;
	assign fault_request  = result_q.fault_request;
	assign fault_kind     = result_q.fault_kind;
	assign mode_now       = result_q.mode_now;
	assign feeds_done     = result_q.feeds_done;
	assign votes_missed   = result_q.votes_missed;
	assign guard_status   = result_q.guard_status;
	assign feed_age       = result_q.feed_age;
	assign foreground_age = result_q.foreground_age;
	assign control_age    = result_q.control_age;

endmodule

`default_nettype wire
